// ===== hw/rtl/ftfc_pkg.sv =====
// ftfc_pkg: field widths, item codes and the transaction record that moves
// down the rule chain of the five-tuple flow classifier.
// No dependencies.
package ftfc_pkg;

  localparam int SLOT_W  = 4;
  localparam int QUEUE_W = 8;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;

  // item kind carried in the mode field
  typedef enum logic {
    MODE_WRITE    = 1'b0,
    MODE_CLASSIFY = 1'b1
  } mode_t;

  // one transaction as it moves from cell to cell, with the running result
  typedef struct packed {
    mode_t                mode;
    logic [SLOT_W-1:0]    slot;
    logic [QUEUE_W-1:0]   queue_number;
    logic [ADDR_W-1:0]    src_addr;
    logic [ADDR_W-1:0]    src_prefix_mask;
    logic [ADDR_W-1:0]    dst_addr;
    logic [ADDR_W-1:0]    dst_prefix_mask;
    logic [PORT_W-1:0]    src_l4_port;
    logic [PORT_W-1:0]    dst_l4_port;
    logic [PROTO_W-1:0]   protocol;
    logic                 found;
    logic [QUEUE_W-1:0]   res_queue;
    logic [SLOT_W-1:0]    res_slot;
  } flow_item_t;

  // one chain stage: occupancy plus transaction
  typedef struct packed {
    logic       valid;
    flow_item_t item;
  } stage_t;

endpackage

// ===== hw/rtl/ftfc_if.sv =====
// ftfc_in_if / ftfc_out_if: valid-ready channels of the flow classifier.
// Depends on ftfc_pkg for the field widths.
interface ftfc_in_if import ftfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SLOT_W-1:0]  slot;
  logic [QUEUE_W-1:0] queue_number;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  src_prefix_mask;
  logic [ADDR_W-1:0]  dst_addr;
  logic [ADDR_W-1:0]  dst_prefix_mask;
  logic [PORT_W-1:0]  src_l4_port;
  logic [PORT_W-1:0]  dst_l4_port;
  logic [PROTO_W-1:0] protocol;

  modport source (
    output valid, mode, slot, queue_number, src_addr, src_prefix_mask,
           dst_addr, dst_prefix_mask, src_l4_port, dst_l4_port, protocol,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, queue_number, src_addr, src_prefix_mask,
           dst_addr, dst_prefix_mask, src_l4_port, dst_l4_port, protocol,
    output ready
  );
endinterface

interface ftfc_out_if import ftfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QUEUE_W-1:0] queue_out;
  logic               hit;
  logic [SLOT_W-1:0]  hit_slot;

  modport source (output valid, queue_out, hit, hit_slot, input ready);
  modport sink   (input valid, queue_out, hit, hit_slot, output ready);
endinterface

// ===== hw/rtl/five_tuple_flow_classifier.sv =====
// five_tuple_flow_classifier: top level, a chain of rule cells and the
// result register. Depends on ftfc_pkg, ftfc_if and ftfc_cell.
//
// Every transaction, rule write or classify, walks the chain of NUM_RULES
// rule cells: it is registered in each cell's stage in turn, slot 0 first,
// and then in the result register. A new transaction is taken every cycle
// while the chain is not held. Writes travel the same chain and update
// their slot when they pass it, so writes and classifies take effect in the
// order they were taken. Writes give no result. The whole chain holds while
// a result waits in the output register and the sink is not ready. Rule
// slots reset empty; slots 16 and up cannot be addressed by the 4-bit slot
// field and stay empty.
module five_tuple_flow_classifier import ftfc_pkg::*; #(
  parameter int NUM_RULES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ftfc_in_if.sink     in_ch,
  ftfc_out_if.source  out_ch
);

  stage_t chain_w [NUM_RULES+1];
  logic   advance;
  stage_t last_w;

  logic               out_valid_r;
  logic [QUEUE_W-1:0] out_queue_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_slot_r;

  // chain moves whenever the result register is free or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  // head of the chain: pack the incoming transaction
  always_comb begin
    chain_w[0].valid                     = in_ch.valid;
    chain_w[0].item.mode                 = mode_t'(in_ch.mode);
    chain_w[0].item.slot                 = in_ch.slot;
    chain_w[0].item.queue_number         = in_ch.queue_number;
    chain_w[0].item.src_addr             = in_ch.src_addr;
    chain_w[0].item.src_prefix_mask      = in_ch.src_prefix_mask;
    chain_w[0].item.dst_addr             = in_ch.dst_addr;
    chain_w[0].item.dst_prefix_mask      = in_ch.dst_prefix_mask;
    chain_w[0].item.src_l4_port          = in_ch.src_l4_port;
    chain_w[0].item.dst_l4_port          = in_ch.dst_l4_port;
    chain_w[0].item.protocol             = in_ch.protocol;
    chain_w[0].item.found                = 1'b0;
    chain_w[0].item.res_queue            = '0;
    chain_w[0].item.res_slot             = '0;
  end

  // rule cells, slot 0 first
  for (genvar k = 0; k < NUM_RULES; k++) begin : g_cell
    ftfc_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .stage_i (chain_w[k]),
      .stage_o (chain_w[k+1])
    );
  end

  assign last_w = chain_w[NUM_RULES];

  // result register, marked valid only by classify transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_w.valid && (last_w.item.mode == MODE_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_queue_r <= last_w.item.res_queue;
      out_hit_r   <= last_w.item.found;
      out_slot_r  <= last_w.item.res_slot;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.queue_out = out_queue_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.hit_slot  = out_slot_r;

endmodule

// ===== hw/rtl/ftfc_cell.sv =====
// ftfc_cell: one rule slot of the classifier chain plus its pipeline stage.
// Depends on ftfc_pkg for the transaction record.
module ftfc_cell import ftfc_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   advance,
  input  stage_t stage_i,
  output stage_t stage_o
);

  localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(CELL_IDX);
  localparam bit                WRITABLE  = CELL_IDX < (1 << SLOT_W);

  // stored rule
  logic               rule_valid_r;
  logic [ADDR_W-1:0]  rule_src_addr_r;
  logic [ADDR_W-1:0]  rule_src_mask_r;
  logic [ADDR_W-1:0]  rule_dst_addr_r;
  logic [ADDR_W-1:0]  rule_dst_mask_r;
  logic [PORT_W-1:0]  rule_src_l4_port_r;
  logic [PORT_W-1:0]  rule_dst_l4_port_r;
  logic [PROTO_W-1:0] rule_proto_r;
  logic [QUEUE_W-1:0] rule_queue_r;

  logic       stage_valid_r;
  flow_item_t stage_item_r;
  flow_item_t stage_item_nxt;
  logic       wr_en;
  logic       rule_match;

  // rule write when a write transaction addressed to this slot passes
  assign wr_en = WRITABLE && advance && stage_i.valid &&
                 (stage_i.item.mode == MODE_WRITE) &&
                 (stage_i.item.slot == CELL_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_valid_r <= 1'b0;
    end else if (wr_en) begin
      rule_valid_r <= (stage_i.item.queue_number != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_src_mask_r    <= stage_i.item.src_prefix_mask;
      rule_src_addr_r    <= stage_i.item.src_addr & stage_i.item.src_prefix_mask;
      rule_dst_mask_r    <= stage_i.item.dst_prefix_mask;
      rule_dst_addr_r    <= stage_i.item.dst_addr & stage_i.item.dst_prefix_mask;
      rule_src_l4_port_r <= stage_i.item.src_l4_port;
      rule_dst_l4_port_r <= stage_i.item.dst_l4_port;
      rule_proto_r       <= stage_i.item.protocol;
      rule_queue_r       <= stage_i.item.queue_number;
    end
  end

  // five-tuple compare: masked addresses; zero ports/protocol match any
  assign rule_match = rule_valid_r &&
    ((rule_proto_r == '0) || (rule_proto_r == stage_i.item.protocol)) &&
    ((stage_i.item.src_addr & rule_src_mask_r) == rule_src_addr_r) &&
    ((stage_i.item.dst_addr & rule_dst_mask_r) == rule_dst_addr_r) &&
    ((rule_src_l4_port_r == '0) ||
     (rule_src_l4_port_r == stage_i.item.src_l4_port)) &&
    ((rule_dst_l4_port_r == '0) ||
     (rule_dst_l4_port_r == stage_i.item.dst_l4_port));

  // first match wins: keep an earlier result, else take this slot
  always_comb begin
    stage_item_nxt = stage_i.item;
    if ((stage_i.item.mode == MODE_CLASSIFY) && !stage_i.item.found && rule_match) begin
      stage_item_nxt.found     = 1'b1;
      stage_item_nxt.res_queue = rule_queue_r;
      stage_item_nxt.res_slot  = CELL_SLOT;
    end
  end

  // pipeline stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (advance) begin
      stage_valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_item_r <= stage_item_nxt;
    end
  end

  assign stage_o = {stage_valid_r, stage_item_r};

endmodule
